FILE: hw/rtl/bslp_pkg.sv
package bslp_pkg;

   localparam int unsigned CodeWidth     = 32;
   localparam int unsigned CntWidth      = 4;
   localparam int unsigned NumKeys       = 4;
   localparam int unsigned KindWidth     = 4;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned SlotWidth     = $clog2(NumKeys);
   localparam int unsigned CountWidth    = $clog2(NumKeys + 1);

   localparam logic [CodeWidth-1:0] AllReleased = '1;

   localparam logic [CntWidth-1:0] HoldPlayStopReset = 4'd4;
   localparam logic [CntWidth-1:0] HoldSeekReset     = 4'd3;
   localparam logic [CntWidth-1:0] SeekGapReset      = 4'd2;

   // Bit positions in the latched press flags.
   localparam int unsigned FlagNext = 0;
   localparam int unsigned FlagPrev = 1;
   localparam int unsigned FlagPlay = 2;
   localparam int unsigned FlagStop = 3;

   typedef enum logic [KindWidth-1:0] {
      EV_RAW        = 4'd0,
      EV_SHORT_NEXT = 4'd1,
      EV_SHORT_PREV = 4'd2,
      EV_SHORT_PLAY = 4'd3,
      EV_SHORT_STOP = 4'd4,
      EV_STOP_LONG  = 4'd5,
      EV_PLAY_LONG  = 4'd6,
      EV_PREV_SEEK  = 4'd7,
      EV_NEXT_SEEK  = 4'd8
   } event_kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CODE_NEXT  = 3'd0,
      CSR_CODE_PREV  = 3'd1,
      CSR_CODE_PLAY  = 3'd2,
      CSR_CODE_STOP  = 3'd3,
      CSR_HOLD_PS    = 3'd4,
      CSR_HOLD_SEEK  = 3'd5,
      CSR_SEEK_GAP   = 3'd6
   } csr_index_type;

   // Short press kinds in release order, indexed by flag position.
   localparam event_kind_type ShortKind [NumKeys] =
      '{EV_SHORT_NEXT, EV_SHORT_PREV, EV_SHORT_PLAY, EV_SHORT_STOP};

   typedef struct packed {
      logic [CodeWidth-1:0] code_next;
      logic [CodeWidth-1:0] code_prev;
      logic [CodeWidth-1:0] code_play;
      logic [CodeWidth-1:0] code_stop;
      logic [CntWidth-1:0]  hold_play_stop;
      logic [CntWidth-1:0]  hold_seek;
      logic [CntWidth-1:0]  seek_gap;
   } cfg_type;

   typedef struct packed {
      logic                scanning;
      logic                tick_skip;
      logic [CntWidth-1:0] play_cnt;
      logic [CntWidth-1:0] stop_cnt;
      logic [CntWidth-1:0] seek_cnt;
      logic [CntWidth-1:0] gap_cnt;
      logic [NumKeys-1:0]  flags;
   } state_type;

   // All result words caused by one input word.
   typedef struct packed {
      event_kind_type [NumKeys-1:0] kinds;
      logic [CodeWidth-1:0]         raw;
      logic [CountWidth-1:0]        count;
   } batch_type;

endpackage

FILE: hw/rtl/bslp_if.sv
interface bslp_req_if import bslp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [CodeWidth-1:0] buttons;

   modport source (output valid, action, buttons, input ready);
   modport sink   (input valid, action, buttons, output ready);
endinterface

interface bslp_rsp_if import bslp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] event_kind;
   logic [CodeWidth-1:0] raw_code;
   logic                 last;

   modport source (output valid, event_kind, raw_code, last, input ready);
   modport sink   (input valid, event_kind, raw_code, last, output ready);
endinterface

FILE: hw/rtl/bslp_classify.sv
module bslp_classify import bslp_pkg::*; (
   input  state_type            state_i,
   input  cfg_type              cfg_i,
   input  logic                 action_i,
   input  logic [CodeWidth-1:0] buttons_i,
   output state_type            state_o,
   output batch_type            batch_o
);

   logic                 hit_next, hit_prev, hit_play, hit_stop;
   logic [CountWidth-1:0] cnt;

   assign hit_next = (buttons_i == cfg_i.code_next);
   assign hit_prev = (buttons_i == cfg_i.code_prev);
   assign hit_play = (buttons_i == cfg_i.code_play);
   assign hit_stop = (buttons_i == cfg_i.code_stop);

   always_comb begin
      state_o = state_i;
      batch_o = '0;
      cnt     = '0;
      if (!action_i) begin
         // A press edge counts only while idle.
         if (!state_i.scanning) begin
            state_o.scanning = 1'b1;
            if (hit_next) begin
               state_o.flags[FlagNext] = 1'b1;
               state_o.tick_skip       = 1'b1;
               state_o.seek_cnt        = cfg_i.hold_seek;
            end else if (hit_prev) begin
               state_o.flags[FlagPrev] = 1'b1;
               state_o.tick_skip       = 1'b1;
               state_o.seek_cnt        = cfg_i.hold_seek;
            end else if (hit_play) begin
               state_o.flags[FlagPlay] = 1'b1;
               state_o.tick_skip       = 1'b0;
               state_o.play_cnt        = cfg_i.hold_play_stop;
            end else if (hit_stop) begin
               state_o.flags[FlagStop] = 1'b1;
               state_o.tick_skip       = 1'b0;
               state_o.stop_cnt        = cfg_i.hold_play_stop;
            end else begin
               batch_o.kinds[0] = EV_RAW;
               batch_o.raw      = buttons_i;
               batch_o.count    = CountWidth'(1);
            end
         end
      end else if (state_i.scanning) begin
         if (state_i.tick_skip) begin
            state_o.tick_skip = 1'b0;
         end else if (buttons_i == AllReleased) begin
            // Release flushes every latched short press in key order.
            for (int i = 0; i < NumKeys; i++) begin
               if (state_i.flags[i]) begin
                  batch_o.kinds[cnt[SlotWidth-1:0]] = ShortKind[i];
                  cnt = cnt + CountWidth'(1);
               end
            end
            batch_o.count     = cnt;
            state_o.flags     = '0;
            state_o.scanning  = 1'b0;
            state_o.tick_skip = 1'b1;
         end else if (hit_stop) begin
            if (state_i.stop_cnt != '0) begin
               state_o.stop_cnt = state_i.stop_cnt - CntWidth'(1);
            end else if (state_i.flags[FlagStop]) begin
               batch_o.kinds[0]        = EV_STOP_LONG;
               batch_o.count           = CountWidth'(1);
               state_o.flags[FlagStop] = 1'b0;
            end
         end else if (hit_play) begin
            if (state_i.play_cnt != '0) begin
               state_o.play_cnt = state_i.play_cnt - CntWidth'(1);
            end else if (state_i.flags[FlagPlay]) begin
               batch_o.kinds[0]        = EV_PLAY_LONG;
               batch_o.count           = CountWidth'(1);
               state_o.flags[FlagPlay] = 1'b0;
            end
         end else if (hit_prev || hit_next) begin
            // Seek repeat: wait out the hold, then one event per gap.
            if (state_i.seek_cnt != '0) begin
               state_o.seek_cnt = state_i.seek_cnt - CntWidth'(1);
            end else begin
               if (hit_prev) begin
                  state_o.flags[FlagPrev] = 1'b0;
               end else begin
                  state_o.flags[FlagNext] = 1'b0;
               end
               if (state_i.gap_cnt != '0) begin
                  state_o.gap_cnt = state_i.gap_cnt - CntWidth'(1);
               end else begin
                  state_o.gap_cnt  = cfg_i.seek_gap;
                  batch_o.kinds[0] = hit_prev ? EV_PREV_SEEK : EV_NEXT_SEEK;
                  batch_o.count    = CountWidth'(1);
               end
            end
         end else begin
            batch_o.kinds[0] = EV_RAW;
            batch_o.raw      = buttons_i;
            batch_o.count    = CountWidth'(1);
         end
      end
   end

endmodule

FILE: hw/rtl/bslp_rsp_queue.sv
module bslp_rsp_queue import bslp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load_i,
   input  batch_type  batch_i,
   output logic       ready_o,
   bslp_rsp_if.source rsp
);

   batch_type             batch_ff, batch_in;
   logic [SlotWidth-1:0]  idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  is_last;
   logic                  take;

   assign is_last = (CountWidth'(idx_ff) + CountWidth'(1)) == batch_ff.count;
   assign take    = busy_ff && rsp.ready;
   // A new word may enter as the last result of the current one leaves.
   assign ready_o = !busy_ff || (take && is_last);

   assign rsp.valid      = busy_ff;
   assign rsp.event_kind = batch_ff.kinds[idx_ff];
   assign rsp.raw_code   = batch_ff.raw;
   assign rsp.last       = is_last;

   always_comb begin
      batch_in = batch_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + SlotWidth'(1);
         end
      end
      if (load_i && batch_i.count != '0) begin
         batch_in = batch_i;
         idx_in   = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
      idx_ff   <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

FILE: hw/rtl/button_short_long_press_detector.sv
// Channel  Dir  Handshake        Payload
// req_bus  in   valid / ready    action, buttons
// rsp_bus  out  valid / ready    event_kind, raw_code, last
// csr      in   csr_we only      csr_index, csr_wdata
//
// A word is classified in the cycle it is accepted; its results (zero to four)
// leave from the result register one per cycle while rsp_bus is not stalled.
// The next word is taken in the cycle the last result of the previous one leaves.
// Reset is synchronous; it resets configuration and state and returns to idle.
// A stall on rsp_bus holds the current result and blocks req_bus once it is full.
module button_short_long_press_detector import bslp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   bslp_req_if.sink                 req_bus,
   bslp_rsp_if.source               rsp_bus,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CodeWidth-1:0]     csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in, state_next;
   batch_type batch;
   logic      accept;
   logic      queue_ready;

   assign req_bus.ready = queue_ready;
   assign accept        = req_bus.valid && queue_ready;

   bslp_classify u_classify (
      .state_i   (state_ff),
      .cfg_i     (cfg_ff),
      .action_i  (req_bus.action),
      .buttons_i (req_bus.buttons),
      .state_o   (state_next),
      .batch_o   (batch)
   );

   bslp_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .load_i  (accept),
      .batch_i (batch),
      .ready_o (queue_ready),
      .rsp     (rsp_bus)
   );

   assign state_in = accept ? state_next : state_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_NEXT: cfg_in.code_next      = csr_wdata;
            CSR_CODE_PREV: cfg_in.code_prev      = csr_wdata;
            CSR_CODE_PLAY: cfg_in.code_play      = csr_wdata;
            CSR_CODE_STOP: cfg_in.code_stop      = csr_wdata;
            CSR_HOLD_PS:   cfg_in.hold_play_stop = csr_wdata[CntWidth-1:0];
            CSR_HOLD_SEEK: cfg_in.hold_seek      = csr_wdata[CntWidth-1:0];
            CSR_SEEK_GAP:  cfg_in.seek_gap       = csr_wdata[CntWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_next      <= '0;
         cfg_ff.code_prev      <= '0;
         cfg_ff.code_play      <= '0;
         cfg_ff.code_stop      <= '0;
         cfg_ff.hold_play_stop <= HoldPlayStopReset;
         cfg_ff.hold_seek      <= HoldSeekReset;
         cfg_ff.seek_gap       <= SeekGapReset;
         state_ff              <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/bslp_checker.sv
module bslp_checker import bslp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [KindWidth-1:0] rsp_event_kind,
   input logic [CodeWidth-1:0] rsp_raw_code,
   input logic                 rsp_last
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_event_kind) && $stable(rsp_raw_code) && $stable(rsp_last))
      else $error("stalled result word changed");

   // Only raw events carry a button word.
   a_raw_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_RAW |-> rsp_raw_code == '0)
      else $error("non-raw event with a nonzero raw code");

   // Event kinds stay within the defined range.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind <= KindWidth'(EV_NEXT_SEEK))
      else $error("undefined event kind");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind button_short_long_press_detector bslp_checker u_bslp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_event_kind (rsp_bus.event_kind),
   .rsp_raw_code   (rsp_bus.raw_code),
   .rsp_last       (rsp_bus.last)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// Tracks the detector state and configuration, predicts the event words each
// accepted button word causes, and checks the event words that come out.
class press_scoreboard;
   typedef struct packed {
      bslp_pkg::event_kind_type kind;
      logic [31:0]              raw;
      logic                     last;
   } press_event_type;

   logic [31:0] code_next, code_prev, code_play, code_stop;
   logic [3:0]  hold_ps, hold_seek, seek_gap;

   bit          scanning;
   bit          tick_skip;
   logic [3:0]  play_cnt, stop_cnt, seek_cnt, gap_cnt;
   logic [3:0]  flags;

   press_event_type expected_events[$];
   int unsigned     errors;

   function new();
      code_next = '0;
      code_prev = '0;
      code_play = '0;
      code_stop = '0;
      hold_ps   = bslp_pkg::HoldPlayStopReset;
      hold_seek = bslp_pkg::HoldSeekReset;
      seek_gap  = bslp_pkg::SeekGapReset;
      scanning  = 1'b0;
      tick_skip = 1'b0;
      play_cnt  = '0;
      stop_cnt  = '0;
      seek_cnt  = '0;
      gap_cnt   = '0;
      flags     = '0;
      errors    = 0;
   endfunction

   function void set_register(bslp_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         bslp_pkg::CSR_CODE_NEXT: code_next = data;
         bslp_pkg::CSR_CODE_PREV: code_prev = data;
         bslp_pkg::CSR_CODE_PLAY: code_play = data;
         bslp_pkg::CSR_CODE_STOP: code_stop = data;
         bslp_pkg::CSR_HOLD_PS:   hold_ps   = data[3:0];
         bslp_pkg::CSR_HOLD_SEEK: hold_seek = data[3:0];
         bslp_pkg::CSR_SEEK_GAP:  seek_gap  = data[3:0];
         default: ;
      endcase
   endfunction

   function void push_event(bslp_pkg::event_kind_type kind, logic [31:0] raw);
      press_event_type ev;
      ev.kind = kind;
      ev.raw  = raw;
      ev.last = 1'b0;
      expected_events.push_back(ev);
   endfunction

   // Once the hold has run out the latch is dropped, and seek events are
   // spaced by the gap count.
   function void seek_step(int unsigned flag_bit, bslp_pkg::event_kind_type kind);
      if (seek_cnt != 0) begin
         seek_cnt--;
      end else begin
         flags[flag_bit] = 1'b0;
         if (gap_cnt != 0) begin
            gap_cnt--;
         end else begin
            gap_cnt = seek_gap;
            push_event(kind, '0);
         end
      end
   endfunction

   // Returns 1 when the word was not simply ignored by the detector.
   function bit note_word(logic action, logic [31:0] b);
      int unsigned first;
      first = expected_events.size();
      if (action == 1'b0) begin
         if (scanning) return 1'b0;
         if (b == code_next) begin
            flags[bslp_pkg::FlagNext] = 1'b1;
            tick_skip = 1'b1;
            seek_cnt = hold_seek;
         end else if (b == code_prev) begin
            flags[bslp_pkg::FlagPrev] = 1'b1;
            tick_skip = 1'b1;
            seek_cnt = hold_seek;
         end else if (b == code_play) begin
            flags[bslp_pkg::FlagPlay] = 1'b1;
            tick_skip = 1'b0;
            play_cnt = hold_ps;
         end else if (b == code_stop) begin
            flags[bslp_pkg::FlagStop] = 1'b1;
            tick_skip = 1'b0;
            stop_cnt = hold_ps;
         end else begin
            push_event(bslp_pkg::EV_RAW, b);
         end
         scanning = 1'b1;
      end else begin
         if (!scanning) return 1'b0;
         if (tick_skip) begin
            tick_skip = 1'b0;
            return 1'b0;
         end
         if (b == bslp_pkg::AllReleased) begin
            if (flags[bslp_pkg::FlagNext]) push_event(bslp_pkg::EV_SHORT_NEXT, '0);
            if (flags[bslp_pkg::FlagPrev]) push_event(bslp_pkg::EV_SHORT_PREV, '0);
            if (flags[bslp_pkg::FlagPlay]) push_event(bslp_pkg::EV_SHORT_PLAY, '0);
            if (flags[bslp_pkg::FlagStop]) push_event(bslp_pkg::EV_SHORT_STOP, '0);
            flags = '0;
            scanning = 1'b0;
            tick_skip = 1'b1;
         end else if (b == code_stop) begin
            if (stop_cnt != 0) begin
               stop_cnt--;
            end else if (flags[bslp_pkg::FlagStop]) begin
               push_event(bslp_pkg::EV_STOP_LONG, '0);
               flags[bslp_pkg::FlagStop] = 1'b0;
            end
         end else if (b == code_play) begin
            if (play_cnt != 0) begin
               play_cnt--;
            end else if (flags[bslp_pkg::FlagPlay]) begin
               push_event(bslp_pkg::EV_PLAY_LONG, '0);
               flags[bslp_pkg::FlagPlay] = 1'b0;
            end
         end else if (b == code_prev) begin
            seek_step(bslp_pkg::FlagPrev, bslp_pkg::EV_PREV_SEEK);
         end else if (b == code_next) begin
            seek_step(bslp_pkg::FlagNext, bslp_pkg::EV_NEXT_SEEK);
         end else begin
            push_event(bslp_pkg::EV_RAW, b);
         end
      end
      if (expected_events.size() > first)
         expected_events[expected_events.size() - 1].last = 1'b1;
      return 1'b1;
   endfunction

   function void check_event(logic [3:0] kind, logic [31:0] raw, logic last);
      press_event_type ev;
      if (expected_events.size() == 0) begin
         $error("unexpected event word: event_kind %0d raw_code %h last %b",
                kind, raw, last);
         errors++;
         return;
      end
      ev = expected_events.pop_front();
      if (kind !== ev.kind) begin
         $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
         errors++;
      end
      if (raw !== ev.raw) begin
         $error("raw_code: expected %h, actual %h", ev.raw, raw);
         errors++;
      end
      if (last !== ev.last) begin
         $error("last: expected %b, actual %b", ev.last, last);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import bslp_pkg::*;

   localparam int unsigned StallLimit = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CodeWidth-1:0] csr_wdata;

   int unsigned send_idle_pct = 17;
   int unsigned recv_idle_pct = 67;
   int unsigned stall_cycles  = 0;
   bit          word_effective;

   press_scoreboard sb;

   bslp_req_if req_bus ();
   bslp_rsp_if rsp_bus ();

   button_short_long_press_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_event(rsp_bus.event_kind, rsp_bus.raw_code, rsp_bus.last);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      while (stall_cycles < StallLimit) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Presents one button word and returns after the edge that accepts it.
   task automatic send_word(input logic act, input logic [CodeWidth-1:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.buttons <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      word_effective = sb.note_word(act, word);
   endtask

   // Waits until every predicted event word has come out and the block is quiet.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CodeWidth-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // The counter registers get random upper bits, which the block must drop.
   task automatic apply_settings(input logic [31:0] c_next, input logic [31:0] c_prev,
                                 input logic [31:0] c_play, input logic [31:0] c_stop,
                                 input logic [3:0] h_ps, input logic [3:0] h_seek,
                                 input logic [3:0] gap);
      write_register(CSR_CODE_NEXT, c_next);
      write_register(CSR_CODE_PREV, c_prev);
      write_register(CSR_CODE_PLAY, c_play);
      write_register(CSR_CODE_STOP, c_stop);
      write_register(CSR_HOLD_PS,   {28'($urandom()), h_ps});
      write_register(CSR_HOLD_SEEK, {28'($urandom()), h_seek});
      write_register(CSR_SEEK_GAP,  {28'($urandom()), gap});
   endtask

   function automatic logic [31:0] random_code();
      case ($urandom_range(4))
         0: return sb.code_next;
         1: return sb.code_prev;
         2: return sb.code_play;
         3: return sb.code_stop;
         default: return AllReleased;
      endcase
   endfunction

   // Mostly press, hold and release sequences, with some stray words mixed in.
   task automatic run_segment(input int unsigned quota);
      int unsigned        done_cnt;
      int unsigned        hold_left;
      int unsigned        pick;
      logic [31:0]        held;
      logic [31:0]        word;
      logic               act;
      done_cnt  = 0;
      hold_left = 0;
      held      = '0;
      while (done_cnt < quota) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            act  = 1'($urandom_range(1));
            word = ($urandom_range(1) != 0) ? $urandom() : random_code();
            send_word(act, word);
         end else if (!sb.scanning) begin
            held = ($urandom_range(4) == 0) ? $urandom() : random_code();
            hold_left = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(12);
            send_word(1'b0, held);
         end else if (hold_left != 0) begin
            word = ($urandom_range(9) == 0) ? random_code() : held;
            hold_left--;
            send_word(1'b1, word);
         end else begin
            send_word(1'b1, AllReleased);
         end
         if (word_effective) done_cnt++;
      end
   endtask

   initial begin
      logic [31:0] shared_a;
      logic [31:0] shared_b;
      req_bus.valid   = 1'b0;
      req_bus.action  = 1'b0;
      req_bus.buttons = '0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_CODE_NEXT;
      csr_wdata       = '0;
      sb = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: every code is zero, so a press matches next first
      // and a held tick matches stop first, which has nothing latched.
      send_word(1'b1, 32'h0000_0000);
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b0, 32'h1234_5678);
      send_word(1'b1, 32'h0000_0000);
      send_word(1'b1, 32'h0000_0000);
      send_word(1'b1, AllReleased);
      settle_block();

      // Play is coded as all ones, so its held tick reads as a release.
      apply_settings(32'h0000_0001, 32'h8000_0000, AllReleased, 32'h7FFF_FFFE,
                     4'd1, 4'd0, 4'd0);
      send_word(1'b0, 32'hA5A5_A5A5);
      send_word(1'b1, 32'hA5A5_A5A5);
      send_word(1'b1, 32'h5A5A_5A5A);
      send_word(1'b1, AllReleased);
      send_word(1'b0, AllReleased);
      send_word(1'b1, AllReleased);
      send_word(1'b0, 32'h7FFF_FFFE);
      send_word(1'b1, 32'h7FFF_FFFE);
      send_word(1'b1, 32'h7FFF_FFFE);
      send_word(1'b1, 32'h7FFF_FFFE);
      send_word(1'b1, AllReleased);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b1, 32'h8000_0000);
      send_word(1'b1, 32'h8000_0000);
      send_word(1'b1, 32'h8000_0000);
      send_word(1'b1, 32'h0000_0001);
      send_word(1'b1, AllReleased);

      for (int seg = 0; seg < 6; seg++) begin
         settle_block();
         case (seg / 2)
            0: begin send_idle_pct = 17; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         shared_a = $urandom();
         shared_b = $urandom();
         case (seg)
            1: apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                              4'd0, 4'd0, 4'd0);
            2: apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                              4'd15, 4'd15, 4'd15);
            3: apply_settings(shared_a, shared_a, shared_b, shared_b,
                              4'($urandom()), 4'($urandom()), 4'($urandom()));
            4: apply_settings(32'h0000_0000, AllReleased, $urandom(), $urandom(),
                              4'($urandom()), 4'($urandom()), 4'($urandom()));
            default: apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                                    4'($urandom()), 4'($urandom()), 4'($urandom()));
         endcase
         run_segment(66);
      end
      settle_block();

      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
hw/rtl/bslp_pkg.sv
hw/rtl/bslp_if.sv
hw/rtl/bslp_classify.sv
hw/rtl/bslp_rsp_queue.sv
hw/rtl/button_short_long_press_detector.sv
hw/rtl/bslp_checker.sv
verif/tb_top.sv
